// File: hw/rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, constants and codes of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

	// Screen geometry and tab stop
	localparam int TAB_STEP    = 8;
	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;

	// Field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;

	// Window limits (the back end clamps window register values to these)
	localparam logic [COL_W-1:0] COL_LIM = COL_W'(SCREEN_COLS - 1);
	localparam logic [ROW_W-1:0] ROW_LIM = ROW_W'(SCREEN_ROWS - 1);

	// Register file reset values
	localparam logic [COL_W-1:0]  WIN_LEFT_RST   = '0;
	localparam logic [ROW_W-1:0]  WIN_TOP_RST    = '0;
	localparam logic [COL_W-1:0]  WIN_RIGHT_RST  = COL_W'(79);
	localparam logic [ROW_W-1:0]  WIN_BOTTOM_RST = ROW_W'(24);
	localparam logic [CHAR_W-1:0] SWAP_CODE_RST  = CHAR_W'(3);
	localparam logic [ATTR_W-1:0] ATTR_RST       = ATTR_W'(8'h07);

	// APB port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Command queue and result buffer
	localparam int CMD_DEPTH_DEF = 2;
	localparam int MAX_RES       = 4;
	localparam int RES_CNT_W     = $clog2(MAX_RES + 1);

	// Character codes
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;

	// Input op codes
	typedef enum logic {
		OP_RAW = 1'b0,
		OP_STR = 1'b1
	} op_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_BEEP   = 2'd2,
		KIND_CURSOR = 2'd3
	} kind_t;

	// Register indexes
	typedef enum logic [2:0] {
		REG_WIN_LEFT   = 3'd0,
		REG_WIN_TOP    = 3'd1,
		REG_WIN_RIGHT  = 3'd2,
		REG_WIN_BOTTOM = 3'd3,
		REG_SWAP_CODE  = 3'd4
	} reg_idx_t;

	// Escape parser states
	typedef enum logic [1:0] {
		ESC_NONE   = 2'd0,
		ESC_CARET  = 2'd1,
		ESC_DIGITS = 2'd2
	} esc_phase_t;

	// Commands from front to back
	typedef enum logic {
		CMD_PUT   = 1'b0,
		CMD_COLOR = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CHAR_W-1:0] data;
	} cmd_t;

	// Configuration seen by the back end
	typedef struct packed {
		logic [COL_W-1:0]  win_left;
		logic [ROW_W-1:0]  win_top;
		logic [COL_W-1:0]  win_right;
		logic [ROW_W-1:0]  win_bottom;
		logic [CHAR_W-1:0] swap_code;
	} cfg_t;

	// One result record, without the last flag
	typedef struct packed {
		kind_t             kind;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [CHAR_W-1:0] glyph;
		logic [ATTR_W-1:0] attr;
	} res_t;

endpackage

// File: hw/rtl/tcce_in_if.sv
// ----------------------------------------------------------------------------
// tcce_in_if
// Character request channel: valid/ready with op and character code.
// ----------------------------------------------------------------------------
interface tcce_in_if import tcce_pkg::*; ();

	logic              valid;
	logic              ready;
	logic              op;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output op, output char_code, input ready);
	modport sink   (input valid, input op, input char_code, output ready);

endinterface

// File: hw/rtl/tcce_out_if.sv
// ----------------------------------------------------------------------------
// tcce_out_if
// Command result channel: valid/ready with the display commands of each request.
// ----------------------------------------------------------------------------
interface tcce_out_if import tcce_pkg::*; ();

	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;
	logic [CHAR_W-1:0] glyph;
	logic [ATTR_W-1:0] attr;
	logic              last;

	modport source (
		output valid, output kind, output col, output row,
		output glyph, output attr, output last, input ready
	);
	modport sink (
		input valid, input kind, input col, input row,
		input glyph, input attr, input last, output ready
	);

endinterface

// File: hw/rtl/tcce_regs.sv
// ----------------------------------------------------------------------------
// tcce_regs
// APB register file: text window bounds and the attribute swap code.
// ----------------------------------------------------------------------------
module tcce_regs import tcce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_left   <= WIN_LEFT_RST;
			cfg_q.win_top    <= WIN_TOP_RST;
			cfg_q.win_right  <= WIN_RIGHT_RST;
			cfg_q.win_bottom <= WIN_BOTTOM_RST;
			cfg_q.swap_code  <= SWAP_CODE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_WIN_LEFT:   cfg_q.win_left   <= pwdata[COL_W-1:0];
				REG_WIN_TOP:    cfg_q.win_top    <= pwdata[ROW_W-1:0];
				REG_WIN_RIGHT:  cfg_q.win_right  <= pwdata[COL_W-1:0];
				REG_WIN_BOTTOM: cfg_q.win_bottom <= pwdata[ROW_W-1:0];
				REG_SWAP_CODE:  cfg_q.swap_code  <= pwdata[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_WIN_LEFT:   prdata = DATA_W'(cfg_q.win_left);
			REG_WIN_TOP:    prdata = DATA_W'(cfg_q.win_top);
			REG_WIN_RIGHT:  prdata = DATA_W'(cfg_q.win_right);
			REG_WIN_BOTTOM: prdata = DATA_W'(cfg_q.win_bottom);
			REG_SWAP_CODE:  prdata = DATA_W'(cfg_q.swap_code);
			default:        prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/tcce_front.sv
// ----------------------------------------------------------------------------
// tcce_front
// Accepts character requests, runs the caret escape parser and turns each
// request into a put or a set-colour command (or nothing) for the queue.
// ----------------------------------------------------------------------------
module tcce_front import tcce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tcce_in_if.sink    chars,
	output logic       cmd_push,
	output cmd_t       cmd,
	input  logic       cmd_full
);

	esc_phase_t        phase_q, phase_d;
	logic [1:0]        dcnt_q, dcnt_d;
	logic [ATTR_W-1:0] dval_q, dval_d;

	logic              accept;
	logic              str_op;
	logic [CHAR_W-1:0] c;
	logic              is_hex;
	logic [3:0]        hex_d;
	logic [1:0]        take_cnt;
	logic [ATTR_W-1:0] take_val;

	assign chars.ready = !cmd_full;
	assign accept      = chars.valid && chars.ready;
	assign str_op      = (op_t'(chars.op) == OP_STR);
	assign c           = chars.char_code;

	// Hex digit decode and digit accumulation (low byte is all that is kept)
	always_comb begin
		is_hex = 1'b1;
		hex_d  = '0;
		if (c >= "0" && c <= "9") begin
			hex_d = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			hex_d = 4'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			hex_d = 4'(c - "A" + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
		take_cnt = dcnt_q;
		take_val = dval_q;
		if (dcnt_q != 2'd3) begin
			if (is_hex) begin
				take_val = {dval_q[3:0], hex_d};
				take_cnt = dcnt_q + 2'd1;
			end else begin
				take_cnt = 2'd3;
			end
		end
	end

	// Next state of the escape parser
	always_comb begin
		phase_d = phase_q;
		dcnt_d  = dcnt_q;
		dval_d  = dval_q;
		if (accept && str_op) begin
			unique case (phase_q)
				ESC_NONE: begin
					if (c == CH_CARET) phase_d = ESC_CARET;
				end
				ESC_CARET: begin
					if (c == CH_CARET) begin
						phase_d = ESC_NONE;
					end else if (c == CH_NUL) begin
						phase_d = ESC_NONE;
						dcnt_d  = '0;
						dval_d  = '0;
					end else begin
						phase_d = ESC_DIGITS;
						dcnt_d  = take_cnt;
						dval_d  = take_val;
					end
				end
				ESC_DIGITS: begin
					if (c == CH_CARET || c == CH_NUL) begin
						phase_d = ESC_NONE;
						dcnt_d  = '0;
						dval_d  = '0;
					end else begin
						dcnt_d = take_cnt;
						dval_d = take_val;
					end
				end
				default: phase_d = ESC_NONE;
			endcase
		end
	end

	// Command issue
	always_comb begin
		cmd_push  = 1'b0;
		cmd.kind  = CMD_PUT;
		cmd.data  = c;
		if (accept) begin
			if (!str_op) begin
				cmd_push = 1'b1;
			end else begin
				unique case (phase_q)
					ESC_NONE: begin
						cmd_push = (c != CH_CARET) && (c != CH_NUL);
					end
					ESC_CARET: begin
						if (c == CH_CARET) begin
							cmd_push = 1'b1;
						end else if (c == CH_NUL) begin
							cmd_push = 1'b1;
							cmd.kind = CMD_COLOR;
							cmd.data = dval_q;
						end
					end
					ESC_DIGITS: begin
						if (c == CH_CARET || c == CH_NUL) begin
							cmd_push = 1'b1;
							cmd.kind = CMD_COLOR;
							cmd.data = dval_q;
						end
					end
					default: cmd_push = 1'b0;
				endcase
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ESC_NONE;
			dcnt_q  <= '0;
			dval_q  <= '0;
		end else begin
			phase_q <= phase_d;
			dcnt_q  <= dcnt_d;
			dval_q  <= dval_d;
		end
	end

endmodule

// File: hw/rtl/tcce_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tcce_cmd_fifo
// Small command queue between the front and the back end.
// ----------------------------------------------------------------------------
module tcce_cmd_fifo import tcce_pkg::*; #(
	parameter int DEPTH = CMD_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hw/rtl/tcce_back.sv
// ----------------------------------------------------------------------------
// tcce_back
// Executes commands: moves the cursor inside the window, builds the list of
// display commands for each put, then plays them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module tcce_back import tcce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	tcce_out_if.source  results
);

	// Cursor and attribute state
	logic [7:0]          cur_col_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [ATTR_W-1:0]   attr_q;

	// Result buffer and output register
	res_t                buf_q [MAX_RES];
	logic [RES_CNT_W-1:0] rem_q;
	logic                out_valid_q;
	res_t                out_q;
	logic                out_last_q;

	// Planning signals
	logic [COL_W-1:0]    l, r;
	logic [ROW_W-1:0]    t, b;
	logic [8:0]          xa, xb;
	logic [5:0]          ya, yb;
	logic                scroll_a, scroll_b, beep, wr;
	logic [ATTR_W-1:0]   attr_n;
	logic [CHAR_W-1:0]   c;
	res_t                cand [MAX_RES];
	logic [MAX_RES-1:0]  cand_v;
	res_t                plan [MAX_RES];
	logic [RES_CNT_W-1:0] plan_cnt;

	logic emit_go, finishing;

	assign c = cmd.data;

	// Window bounds, cursor moves and the ordered command list
	always_comb begin
		l = (cfg.win_left   > COL_LIM) ? COL_LIM : cfg.win_left;
		r = (cfg.win_right  > COL_LIM) ? COL_LIM : cfg.win_right;
		t = (cfg.win_top    > ROW_LIM) ? ROW_LIM : cfg.win_top;
		b = (cfg.win_bottom > ROW_LIM) ? ROW_LIM : cfg.win_bottom;

		// wrap / scroll before the character
		xa       = {1'b0, cur_col_q};
		ya       = {1'b0, cur_row_q};
		scroll_a = 1'b0;
		if (xa > 9'(r)) begin
			xa = 9'(l);
			ya = ya + 6'd1;
		end
		if (ya > 6'(b)) begin
			ya       = 6'(b);
			xa       = 9'(l);
			scroll_a = 1'b1;
		end

		// the character itself; fixed controls win over the swap code
		xb     = xa;
		yb     = ya;
		attr_n = attr_q;
		beep   = 1'b0;
		wr     = 1'b0;
		if (c == CH_LF) begin
			yb = ya + 6'd1;
		end else if (c == CH_CR) begin
			xb = 9'(l);
		end else if (c == CH_TAB) begin
			xb = xa + 9'(TAB_STEP);
		end else if (c == CH_BEL) begin
			beep = 1'b1;
		end else if (c == CH_BS) begin
			if (xa > 9'(l)) begin
				xb = xa - 9'd1;
			end else if (ya > 6'(t)) begin
				xb = 9'(r);
				yb = ya - 6'd1;
			end
		end else if (c == cfg.swap_code) begin
			attr_n = {attr_q[3:0], attr_q[7:4]};
		end else begin
			wr = 1'b1;
			xb = xa + 9'd1;
		end

		// wrap / scroll after the character
		scroll_b = 1'b0;
		if (xb > 9'(r)) begin
			xb = 9'(l);
			yb = yb + 6'd1;
		end
		if (yb > 6'(b)) begin
			yb       = 6'(b);
			xb       = 9'(l);
			scroll_b = 1'b1;
		end

		cand[0]   = '{kind: KIND_SCROLL, col: l, row: b, glyph: CH_SPACE, attr: attr_q};
		cand_v[0] = scroll_a;
		if (beep) begin
			cand[1] = '{kind: KIND_BEEP, col: '0, row: '0, glyph: '0, attr: '0};
		end else begin
			cand[1] = '{kind: KIND_WRITE, col: xa[COL_W-1:0], row: ya[ROW_W-1:0],
				glyph: c, attr: attr_q};
		end
		cand_v[1] = beep || wr;
		cand[2]   = '{kind: KIND_SCROLL, col: l, row: b, glyph: CH_SPACE, attr: attr_n};
		cand_v[2] = scroll_b;
		cand[3]   = '{kind: KIND_CURSOR, col: xb[COL_W-1:0], row: yb[ROW_W-1:0],
			glyph: '0, attr: '0};
		cand_v[3] = 1'b1;
	end

	// Pack the present commands to the front of the plan
	always_comb begin
		plan_cnt = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			plan[i] = cand[MAX_RES-1];
		end
		for (int i = 0; i < MAX_RES; i++) begin
			if (cand_v[i]) begin
				plan[plan_cnt[$clog2(MAX_RES)-1:0]] = cand[i];
				plan_cnt = plan_cnt + 1'b1;
			end
		end
	end

	// Playout control: next command is taken as the last result leaves
	assign emit_go   = (rem_q != '0) && (!out_valid_q || results.ready);
	assign finishing = emit_go && (rem_q == RES_CNT_W'(1));
	assign cmd_pop   = cmd_valid && ((rem_q == '0) || finishing);

	// Result buffer payload
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.kind == CMD_PUT) begin
			buf_q <= plan;
		end else if (emit_go) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	// Cursor, attribute and remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			attr_q    <= ATTR_RST;
			rem_q     <= '0;
		end else if (cmd_pop) begin
			if (cmd.kind == CMD_PUT) begin
				cur_col_q <= xb[7:0];
				cur_row_q <= yb[ROW_W-1:0];
				attr_q    <= attr_n;
				rem_q     <= plan_cnt;
			end else begin
				attr_q <= cmd.data;
				rem_q  <= '0;
			end
		end else if (emit_go) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_q      <= buf_q[0];
			out_last_q <= (rem_q == RES_CNT_W'(1));
		end
	end

	assign results.valid = out_valid_q;
	assign results.kind  = out_q.kind;
	assign results.col   = out_q.col;
	assign results.row   = out_q.row;
	assign results.glyph = out_q.glyph;
	assign results.attr  = out_q.attr;
	assign results.last  = out_last_q;

endmodule

// File: hw/rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text console cursor engine: characters in, display commands out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  chars    in   valid/ready      op, char_code
//  results  out  valid/ready      kind, col, row, glyph, attr, last
//  apb      in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
//  A character is accepted whenever the command queue has room;
//  escape bytes only update the parser, a closing caret or NUL queues a colour command.
//  A put yields 1 to 4 results, one per cycle while the receiver is ready.
//  Queue and output register let either side stall; a full queue holds off requests.
//  Reset (arst_n low) clears cursor and escape state, sets color 0x07 and
//  loads the register defaults.
// ----------------------------------------------------------------------------
module text_console_cursor_engine import tcce_pkg::*; #(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	tcce_in_if.sink           chars,
	tcce_out_if.source        results
);

	cfg_t cfg;
	cmd_t push_cmd, pop_cmd;
	logic push, full, pop, cmd_valid;

	tcce_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcce_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.cmd_push (push),
		.cmd      (push_cmd),
		.cmd_full (full)
	);

	tcce_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.valid     (cmd_valid)
	);

	tcce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (pop_cmd),
		.cmd_pop   (pop),
		.results   (results)
	);

endmodule

// File: hw/rtl/tcce_checker.sv
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tcce_checker import tcce_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input kind_t             res_kind,
	input logic [COL_W-1:0]  res_col,
	input logic [ROW_W-1:0]  res_row,
	input logic [CHAR_W-1:0] res_glyph,
	input logic [ATTR_W-1:0] res_attr,
	input logic              res_last
);

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind)
			&& $stable(res_col) && $stable(res_row) && $stable(res_last))
		else $error("result changed while stalled");

	// Every put ends in a cursor update, and only there
	a_cursor_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_last == (res_kind == KIND_CURSOR)))
		else $error("last flag does not match cursor command");

	// Scroll fill is blank
	a_scroll_blank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_SCROLL |-> res_glyph == CH_SPACE)
		else $error("scroll fill is not a blank");

	// Beep and cursor carry no glyph or attribute
	a_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_BEEP || res_kind == KIND_CURSOR)
			|-> res_glyph == '0 && res_attr == '0)
		else $error("beep or cursor carries glyph or attribute");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_kind  (results.kind),
	.res_col   (results.col),
	.res_row   (results.row),
	.res_glyph (results.glyph),
	.res_attr  (results.attr),
	.res_last  (results.last)
);

// File: tb/cursor_cmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_cmd_checker
// Watches the request, command and register ports of the console engine.
// Keeps its own copy of cursor, color and escape state. For every accepted
// request it predicts the display commands and compares each command that
// arrives with the oldest one still pending.
// ----------------------------------------------------------------------------
module cursor_cmd_checker import tcce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	tcce_in_if                chars,
	tcce_out_if               results,
	output int                errors,
	output int                pending,
	output int                checked,
	output int                scrolls
);

	localparam logic [CHAR_W-1:0] CH_DIG0  = "0";
	localparam logic [CHAR_W-1:0] CH_DIG9  = "9";
	localparam logic [CHAR_W-1:0] CH_LOW_A = "a";
	localparam logic [CHAR_W-1:0] CH_LOW_F = "f";
	localparam logic [CHAR_W-1:0] CH_UP_A  = "A";
	localparam logic [CHAR_W-1:0] CH_UP_F  = "F";

	typedef struct packed {
		res_t cmd;
		logic last;
	} console_cmd_t;

	// Register shadows, updated from observed bus writes
	logic [COL_W-1:0]  reg_left, reg_right;
	logic [ROW_W-1:0]  reg_top, reg_bottom;
	logic [CHAR_W-1:0] reg_swap;

	// Predicted console state
	logic [7:0]        cur_col;
	logic [ROW_W-1:0]  cur_row;
	logic [ATTR_W-1:0] colour;
	esc_phase_t        esc;
	logic [1:0]        hex_cnt;
	logic [11:0]       hex_val;

	// Working cursor and clamped window while one request is handled
	int unsigned pos_x, pos_y, lim_l, lim_r, lim_t, lim_b;

	console_cmd_t step_cmds[$];
	console_cmd_t pending_cmds[$];

	int fail_count   = 0;
	int check_count  = 0;
	int scroll_count = 0;
	int waiting      = 0;

	assign errors  = fail_count;
	assign pending = waiting;
	assign checked = check_count;
	assign scrolls = scroll_count;

	function automatic int unsigned clamp(int unsigned v, int unsigned lim);
		return (v > lim) ? lim : v;
	endfunction

	task automatic report(input string msg);
		$display("[%0t] checker: %s", $time, msg);
		fail_count++;
	endtask

	// At most MAX_RES commands per request
	task automatic push_cmd(input kind_t k, input int unsigned x, input int unsigned y,
			input logic [CHAR_W-1:0] g, input logic [ATTR_W-1:0] a);
		console_cmd_t e;
		e.cmd.kind  = k;
		e.cmd.col   = x[COL_W-1:0];
		e.cmd.row   = y[ROW_W-1:0];
		e.cmd.glyph = g;
		e.cmd.attr  = a;
		e.last      = 1'b0;
		if (step_cmds.size() < MAX_RES)
			step_cmds.push_back(e);
	endtask

	// Past the right edge wraps to the next row; below the bottom scrolls
	task automatic wrap_cursor();
		if (pos_x > lim_r) begin
			pos_x = lim_l;
			pos_y++;
		end
		if (pos_y > lim_b) begin
			pos_y = lim_b;
			pos_x = lim_l;
			push_cmd(KIND_SCROLL, lim_l, lim_b, CH_SPACE, colour);
		end
	endtask

	task automatic put_glyph(input logic [CHAR_W-1:0] c);
		lim_l = clamp(reg_left, COL_LIM);
		lim_r = clamp(reg_right, COL_LIM);
		lim_t = clamp(reg_top, ROW_LIM);
		lim_b = clamp(reg_bottom, ROW_LIM);
		pos_x = cur_col;
		pos_y = cur_row;
		wrap_cursor();
		// fixed control codes win over the swap code
		if (c == CH_LF)
			pos_y++;
		else if (c == CH_CR)
			pos_x = lim_l;
		else if (c == CH_TAB)
			pos_x += TAB_STEP;
		else if (c == CH_BEL)
			push_cmd(KIND_BEEP, 0, 0, '0, '0);
		else if (c == CH_BS) begin
			if (pos_x > lim_l)
				pos_x--;
			else if (pos_y > lim_t) begin
				pos_x = lim_r;
				pos_y--;
			end
		end else if (c == reg_swap)
			colour = {colour[3:0], colour[7:4]};
		else begin
			push_cmd(KIND_WRITE, pos_x, pos_y, c, colour);
			pos_x++;
		end
		wrap_cursor();
		cur_col = pos_x[7:0];
		cur_row = pos_y[ROW_W-1:0];
		push_cmd(KIND_CURSOR, pos_x, pos_y, '0, '0);
	endtask

	task automatic commit_colour();
		colour  = hex_val[7:0];
		esc     = ESC_NONE;
		hex_cnt = '0;
		hex_val = '0;
	endtask

	// Up to three hex digits; a non-hex byte closes the number
	task automatic take_digit(input logic [CHAR_W-1:0] c);
		logic [3:0] d;
		if (hex_cnt == 2'd3)
			return;
		if (c >= CH_DIG0 && c <= CH_DIG9)
			d = 4'(c - CH_DIG0);
		else if (c >= CH_LOW_A && c <= CH_LOW_F)
			d = 4'(c - CH_LOW_A + 8'd10);
		else if (c >= CH_UP_A && c <= CH_UP_F)
			d = 4'(c - CH_UP_A + 8'd10);
		else begin
			hex_cnt = 2'd3;
			return;
		end
		hex_val = {hex_val[7:0], d};
		hex_cnt++;
	endtask

	task automatic predict_request(input op_t op, input logic [CHAR_W-1:0] c);
		step_cmds.delete();
		if (op == OP_RAW)
			put_glyph(c);
		else begin
			case (esc)
			ESC_NONE: begin
				if (c == CH_CARET)
					esc = ESC_CARET;
				else if (c != CH_NUL)
					put_glyph(c);
			end
			ESC_CARET: begin
				if (c == CH_CARET) begin
					esc = ESC_NONE;
					put_glyph(c);
				end else if (c == CH_NUL)
					commit_colour();
				else begin
					esc = ESC_DIGITS;
					take_digit(c);
				end
			end
			default: begin
				if (c == CH_CARET || c == CH_NUL)
					commit_colour();
				else
					take_digit(c);
			end
			endcase
		end
		if (step_cmds.size() > 0)
			step_cmds[step_cmds.size() - 1].last = 1'b1;
		foreach (step_cmds[i])
			pending_cmds.push_back(step_cmds[i]);
	endtask

	task automatic check_cmd();
		console_cmd_t e;
		if (pending_cmds.size() == 0) begin
			report($sformatf("unexpected command kind=%0d col=%0d row=%0d glyph=%02h attr=%02h",
				results.kind, results.col, results.row, results.glyph, results.attr));
			return;
		end
		e = pending_cmds.pop_front();
		check_count++;
		if (e.cmd.kind == KIND_SCROLL)
			scroll_count++;
		if (results.kind !== e.cmd.kind || results.col !== e.cmd.col ||
				results.row !== e.cmd.row || results.glyph !== e.cmd.glyph ||
				results.attr !== e.cmd.attr || results.last !== e.last)
			report($sformatf({"command %0d: got kind=%0d col=%0d row=%0d glyph=%02h attr=%02h ",
				"last=%0b, want kind=%0d col=%0d row=%0d glyph=%02h attr=%02h last=%0b"},
				check_count, results.kind, results.col, results.row, results.glyph,
				results.attr, results.last, e.cmd.kind, e.cmd.col, e.cmd.row,
				e.cmd.glyph, e.cmd.attr, e.last));
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		case (reg_idx_t'(a[ADDR_W-1:2]))
		REG_WIN_LEFT:   reg_left   = d[COL_W-1:0];
		REG_WIN_TOP:    reg_top    = d[ROW_W-1:0];
		REG_WIN_RIGHT:  reg_right  = d[COL_W-1:0];
		REG_WIN_BOTTOM: reg_bottom = d[ROW_W-1:0];
		REG_SWAP_CODE:  reg_swap   = d[CHAR_W-1:0];
		default: ;
		endcase
	endtask

	// Commands leave before new requests are predicted within one edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_left   = WIN_LEFT_RST;
			reg_top    = WIN_TOP_RST;
			reg_right  = WIN_RIGHT_RST;
			reg_bottom = WIN_BOTTOM_RST;
			reg_swap   = SWAP_CODE_RST;
			cur_col    = '0;
			cur_row    = '0;
			colour     = ATTR_RST;
			esc        = ESC_NONE;
			hex_cnt    = '0;
			hex_val    = '0;
			pending_cmds.delete();
		end else begin
			if (psel && penable && pwrite && pready)
				write_reg(paddr, pwdata);
			if (results.valid && results.ready)
				check_cmd();
			if (chars.valid && chars.ready)
				predict_request(op_t'(chars.op), chars.char_code);
		end
		waiting = pending_cmds.size();
	end

endmodule

// File: tb/text_console_cursor_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_tb
// Drives the console engine with raw puts, string text, caret colour escapes
// and control codes under a series of window settings and idle mixes; the
// checker beside the block predicts and compares every display command.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_tb;
	import tcce_pkg::*;

	localparam int LIMIT_NS     = 5_000_000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [CHAR_W-1:0] CH_DIG0  = "0";
	localparam logic [CHAR_W-1:0] CH_LOW_A = "a";
	localparam logic [CHAR_W-1:0] CH_UP_A  = "A";
	localparam logic [CHAR_W-1:0] CH_LOW_G = "g";

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int requests_sent = 0;
	int settings_used = 0;
	logic [CHAR_W-1:0] swap_now;

	int errors, pending, checked, scrolls;

	tcce_in_if  chars_if ();
	tcce_out_if results_if ();

	text_console_cursor_engine dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.chars   (chars_if),
		.results (results_if)
	);

	cursor_cmd_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.chars   (chars_if),
		.results (results_if),
		.errors  (errors),
		.pending (pending),
		.checked (checked),
		.scrolls (scrolls)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Command receiver stalls at random
	always @(negedge clk) begin
		results_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Caller sits at a falling edge; returns at the falling edge after acceptance
	task automatic send_char(input op_t op, input logic [CHAR_W-1:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.op        <= op;
		chars_if.char_code <= c;
		do @(posedge clk); while (!chars_if.ready);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Window and swap code change only once the engine has gone quiet
	task automatic set_window(input int l, input int t, input int r, input int b,
			input logic [CHAR_W-1:0] s);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		apb_write(REG_WIN_LEFT, DATA_W'(l));
		apb_write(REG_WIN_TOP, DATA_W'(t));
		apb_write(REG_WIN_RIGHT, DATA_W'(r));
		apb_write(REG_WIN_BOTTOM, DATA_W'(b));
		apb_write(REG_SWAP_CODE, DATA_W'(s));
		swap_now = s;
		settings_used++;
	endtask

	function automatic logic [CHAR_W-1:0] rand_hex_digit();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return CH_DIG0 + CHAR_W'(v);
		return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + CHAR_W'(v - 10);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_control();
		logic [CHAR_W-1:0] c;
		case ($urandom_range(0, 5))
		0:       c = CH_BEL;
		1:       c = CH_BS;
		2:       c = CH_TAB;
		3:       c = CH_LF;
		4:       c = CH_CR;
		default: c = swap_now;
		endcase
		return c;
	endfunction

	// Short string, mostly printable, sometimes closed by NUL
	task automatic send_text();
		int n;
		n = $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				send_char(OP_STR, rand_control());
			else
				send_char(OP_STR, CHAR_W'($urandom_range(32, 126)));
		end
		if ($urandom_range(0, 1))
			send_char(OP_STR, CH_NUL);
	endtask

	// Caret, zero to four hex digits, maybe junk or a raw put, then caret or NUL
	task automatic send_colour_escape();
		int ndig;
		ndig = $urandom_range(0, 4);
		send_char(OP_STR, CH_CARET);
		repeat (ndig)
			send_char(OP_STR, rand_hex_digit());
		if ($urandom_range(0, 3) == 0)
			send_char(OP_STR, CH_LOW_G + CHAR_W'($urandom_range(0, 19)));
		if ($urandom_range(0, 5) == 0)
			send_char(OP_RAW, CHAR_W'($urandom_range(32, 126)));
		if ($urandom_range(0, 3) == 0)
			send_char(OP_STR, CH_NUL);
		else
			send_char(OP_STR, CH_CARET);
	endtask

	task automatic send_random_run(input int count);
		int start;
		start = requests_sent;
		while (requests_sent - start < count) begin
			if ($urandom_range(0, 59) == 0)
				wait_drained();
			case ($urandom_range(0, 9))
			0, 1: send_char(OP_RAW, CHAR_W'($urandom_range(0, 255)));
			2:    send_char(OP_RAW, rand_control());
			3, 4: send_text();
			5, 6: send_colour_escape();
			7: begin
				send_char(OP_STR, CH_CARET);
				send_char(OP_STR, CH_CARET);
			end
			8:    send_char(op_t'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)));
			default: repeat ($urandom_range(2, 6)) send_char(OP_RAW, CH_LF);
			endcase
		end
	endtask

	// Run limit
	initial begin
		#(LIMIT_NS);
		$display("text_console_cursor_engine_tb: done, errors");
		$finish;
	end

	initial begin
		chars_if.valid     = 1'b0;
		chars_if.op        = OP_RAW;
		chars_if.char_code = '0;
		results_if.ready   = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		swap_now           = SWAP_CODE_RST;
		settings_used      = 1;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender idles a third of the time, receiver most of the time
		send_idle_pct = 34;
		recv_idle_pct = 73;

		// Directed requests under the reset window
		send_char(OP_RAW, "A");
		send_char(OP_RAW, 8'hFF);
		send_char(OP_RAW, CH_NUL);
		send_char(OP_RAW, SWAP_CODE_RST);
		send_char(OP_RAW, CH_BEL);
		send_char(OP_RAW, CH_TAB);
		send_char(OP_RAW, CH_LF);
		send_char(OP_RAW, CH_CR);
		send_char(OP_RAW, CH_BS);       // wraps to the right edge of the row above
		send_char(OP_RAW, CH_CR);
		send_char(OP_RAW, CH_BS);       // top-left corner: stays put
		send_char(OP_STR, "H");
		send_char(OP_STR, CH_CARET);    // double caret prints a caret
		send_char(OP_STR, CH_CARET);
		send_char(OP_STR, CH_CARET);    // three digits, extras ignored
		send_char(OP_STR, "F");
		send_char(OP_STR, "a");
		send_char(OP_STR, "7");
		send_char(OP_STR, "x");
		send_char(OP_RAW, "Z");         // raw put leaves the escape open
		send_char(OP_STR, CH_CARET);
		send_char(OP_STR, CH_CARET);    // non-hex, then NUL commits zero
		send_char(OP_STR, "g");
		send_char(OP_STR, CH_NUL);
		send_char(OP_STR, CH_NUL);      // plain terminator
		send_char(OP_STR, CH_CARET);    // caret then NUL
		send_char(OP_STR, CH_NUL);

		// Small window, with a full drain in the middle
		set_window(5, 3, 20, 8, 8'h1B);
		send_random_run(45);
		wait_drained();
		send_random_run(45);

		// Roles of sender and receiver swapped
		send_idle_pct = 73;
		recv_idle_pct = 34;

		// Oversized right and bottom saturate; raw NUL swaps colours
		set_window(0, 0, 127, 31, 8'h00);
		send_random_run(90);

		// Inverted window
		set_window(70, 20, 10, 5, 8'hFF);
		send_random_run(60);

		send_idle_pct = 0;
		recv_idle_pct = 0;

		// Single cell at the far corner, left and top saturating; caret swaps
		set_window(127, 31, 79, 24, CH_CARET);
		send_random_run(50);

		// Single cell at the origin
		set_window(0, 0, 0, 0, "A");
		send_random_run(45);

		// Any register values at all
		set_window($urandom_range(0, 127), $urandom_range(0, 31), $urandom_range(0, 127),
			$urandom_range(0, 31), CHAR_W'($urandom_range(0, 255)));
		send_random_run(50);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d requests (puts, strings, colour escapes) under %0d window settings",
			requests_sent, settings_used);
		$display("and three idle mixes; %0d commands compared, %0d of them scrolls",
			checked, scrolls);
		if (pending != 0)
			$display("%0d predicted commands never arrived", pending);
		if (errors == 0 && pending == 0)
			$display("text_console_cursor_engine_tb: done, clean");
		else
			$display("text_console_cursor_engine_tb: done, errors");
		$finish;
	end

endmodule
